[hdl/dpt_pkg.sv]
`default_nettype none

package dpt_pkg;

    // Width of one counter half. The wide counter is twice this.
    localparam int HALF_BITS = 32;
    localparam int WIDE_BITS = 2 * HALF_BITS;

    localparam logic [31:0] ID_VALUE       = 32'h4443_1100;
    localparam logic [31:0] STAT_BITS      = 32'h000A_000A;
    localparam logic [31:0] ENABLE_BITS    = 32'h0005_0005;
    localparam logic [31:0] GC_PLUS_ENABLE = 32'h0000_0010;

    localparam int ENA_SHIFT_LO = 6;
    localparam int ENA_SHIFT_HI = 22;

    // Bit positions in the interrupt control and status register.
    localparam int INT_EN_LO   = 0;
    localparam int INT_STAT_LO = 1;
    localparam int INT_EN_HI   = 16;
    localparam int INT_STAT_HI = 17;

    // Enable mode codes.
    localparam logic [1:0] ENA_OFF     = 2'd0;
    localparam logic [1:0] ENA_ONESHOT = 2'd1;
    localparam logic [1:0] ENA_RELOAD  = 2'd3;

    // Global control timer mode that splits the counter into two halves.
    localparam logic [1:0] GMODE_SPLIT = 2'd1;

    // Register word addresses (byte offset divided by four).
    localparam logic [5:0] WA_ID     = 6'h00;
    localparam logic [5:0] WA_EMU    = 6'h01;
    localparam logic [5:0] WA_CNT_LO = 6'h04;
    localparam logic [5:0] WA_CNT_HI = 6'h05;
    localparam logic [5:0] WA_PRD0   = 6'h06;
    localparam logic [5:0] WA_PRD1   = 6'h07;
    localparam logic [5:0] WA_TCR    = 6'h08;
    localparam logic [5:0] WA_TGCR   = 6'h09;
    localparam logic [5:0] WA_WDT    = 6'h0A;
    localparam logic [5:0] WA_REL0   = 6'h0D;
    localparam logic [5:0] WA_REL1   = 6'h0E;
    localparam logic [5:0] WA_CAP0   = 6'h0F;
    localparam logic [5:0] WA_CAP1   = 6'h10;
    localparam logic [5:0] WA_INTCTL = 6'h11;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_low;
        logic        irq_high;
        logic        unmapped_access;
    } t_result;

    // Byte lanes selected by an access of the given size, before lane shift.
    function automatic logic [31:0] lane_mask(input logic [2:0] size);
        logic [31:0] m;
        case (size)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] reg_take(input logic [31:0] v,
                                             input logic [7:0]  off,
                                             input logic [2:0]  size);
        logic [4:0] sh;
        sh = {off[1:0], 3'b000};
        return (v >> sh) & lane_mask(size);
    endfunction

    function automatic logic [31:0] reg_merge(input logic [31:0] old,
                                              input logic [7:0]  off,
                                              input logic [31:0] val,
                                              input logic [2:0]  size);
        logic [4:0]  sh;
        logic [31:0] m;
        sh = {off[1:0], 3'b000};
        m  = lane_mask(size) << sh;
        return (old & ~m) | ((val << sh) & m);
    endfunction

endpackage

`default_nettype wire

[hdl/dpt_ifs.sv]
`default_nettype none

interface dpt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;

    modport source (output valid, operation, offset, access_size, write_data,
                    input ready);
    modport sink (input valid, operation, offset, access_size, write_data,
                  output ready);
endinterface

interface dpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_low;
    logic        irq_high;
    logic        unmapped_access;

    modport source (output valid, read_data, irq_low, irq_high, unmapped_access,
                    input ready);
    modport sink (input valid, read_data, irq_low, irq_high, unmapped_access,
                  output ready);
endinterface

`default_nettype wire

[hdl/dpt_in_stage.sv]
`default_nettype none

module dpt_in_stage (
    input  wire            i_clk,
    input  wire            i_rst_n,
    dpt_cmd_if.sink        i_cmd,
    input  wire            i_take,
    output logic           o_valid,
    output dpt_pkg::t_item o_item
);

    logic           r_valid;
    dpt_pkg::t_item r_item;
    logic           w_ready;

    // The register frees up in the same cycle its transaction moves on.
    assign w_ready     = !r_valid || i_take;
    assign i_cmd.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && w_ready) begin
            r_item.operation   <= i_cmd.operation;
            r_item.offset      <= i_cmd.offset;
            r_item.access_size <= i_cmd.access_size;
            r_item.write_data  <= i_cmd.write_data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hdl/dpt_core.sv]
`default_nettype none

module dpt_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_take,
    input  dpt_pkg::t_item   i_item,
    output dpt_pkg::t_result o_res
);

    localparam int H = dpt_pkg::HALF_BITS;
    localparam int W = dpt_pkg::WIDE_BITS;
    localparam logic [W-1:0] LOW_HALF_MASK = {{H{1'b0}}, {H{1'b1}}};

    logic [31:0]  r_tcr, n_tcr;
    logic [31:0]  r_gctl, n_gctl;
    logic [31:0]  r_emu, n_emu;
    logic [31:0]  r_wdt, n_wdt;
    logic [31:0]  r_icsr, n_icsr;
    logic [31:0]  r_prd0, n_prd0;
    logic [31:0]  r_prd1, n_prd1;
    logic [31:0]  r_rel0, n_rel0;
    logic [31:0]  r_rel1, n_rel1;
    logic [W-1:0] r_cnt_main, n_cnt_main;
    logic [H-1:0] r_cnt_hi, n_cnt_hi;
    logic [1:0]   r_run, n_run;

    logic         split, n_split;
    logic [1:0]   ena0, ena1;
    logic [W-1:0] prd0;
    logic         match0, match1;
    logic         plus_en;
    logic [W-1:0] main_inc;
    logic [31:0]  cur_word;
    logic [31:0]  wr_new;
    logic         mapped_rd, mapped_wr;
    logic [5:0]   wa;

    assign split   = r_gctl[3:2] == dpt_pkg::GMODE_SPLIT;
    assign ena0    = r_tcr[dpt_pkg::ENA_SHIFT_LO +: 2];
    assign ena1    = r_tcr[dpt_pkg::ENA_SHIFT_HI +: 2];
    assign plus_en = (r_gctl & dpt_pkg::GC_PLUS_ENABLE) != 32'd0;
    assign prd0    = split ? {{H{1'b0}}, r_prd0[H-1:0]}
                           : {r_prd1[H-1:0], r_prd0[H-1:0]};
    assign match0  = r_cnt_main == prd0;
    assign match1  = r_cnt_hi == r_prd1[H-1:0];
    assign main_inc = (r_cnt_main + W'(1)) & (split ? LOW_HALF_MASK : {W{1'b1}});
    assign wa      = i_item.offset[7:2];

    // Register decode: current value and which accesses are mapped.
    always_comb begin
        cur_word  = 32'd0;
        mapped_rd = 1'b1;
        mapped_wr = 1'b1;
        unique case (wa) inside
            dpt_pkg::WA_ID: begin
                cur_word  = dpt_pkg::ID_VALUE;
                mapped_wr = 1'b0;
            end
            dpt_pkg::WA_EMU:    cur_word = r_emu;
            dpt_pkg::WA_CNT_LO: cur_word = 32'(r_cnt_main[H-1:0]);
            dpt_pkg::WA_CNT_HI: cur_word = split ? 32'(r_cnt_hi)
                                                 : 32'(r_cnt_main[W-1:H]);
            dpt_pkg::WA_PRD0:   cur_word = r_prd0;
            dpt_pkg::WA_PRD1:   cur_word = r_prd1;
            dpt_pkg::WA_TCR:    cur_word = r_tcr;
            dpt_pkg::WA_TGCR:   cur_word = r_gctl;
            dpt_pkg::WA_WDT:    cur_word = r_wdt;
            dpt_pkg::WA_REL0:   cur_word = r_rel0;
            dpt_pkg::WA_REL1:   cur_word = r_rel1;
            dpt_pkg::WA_CAP0, dpt_pkg::WA_CAP1: begin
                mapped_wr = 1'b0;
            end
            dpt_pkg::WA_INTCTL: cur_word = r_icsr;
            default: begin
                mapped_rd = 1'b0;
                mapped_wr = 1'b0;
            end
        endcase
    end

    // The high count word and the interrupt register merge into zero, so
    // bytes not written clear.
    assign wr_new = dpt_pkg::reg_merge(
        (wa == dpt_pkg::WA_CNT_HI || wa == dpt_pkg::WA_INTCTL) ? 32'd0 : cur_word,
        i_item.offset, i_item.write_data, i_item.access_size);

    always_comb begin
        n_tcr      = r_tcr;
        n_gctl     = r_gctl;
        n_emu      = r_emu;
        n_wdt      = r_wdt;
        n_icsr     = r_icsr;
        n_prd0     = r_prd0;
        n_prd1     = r_prd1;
        n_rel0     = r_rel0;
        n_rel1     = r_rel1;
        n_cnt_main = r_cnt_main;
        n_cnt_hi   = r_cnt_hi;
        n_run      = r_run;
        n_split    = split;
        o_res      = '0;

        case (i_item.operation)
            dpt_pkg::OP_TICK: begin
                if (r_run[0]) begin
                    if (match0) begin
                        n_icsr[dpt_pkg::INT_STAT_LO] = 1'b1;
                        o_res.irq_low = !plus_en || r_icsr[dpt_pkg::INT_EN_LO];
                        if (ena0 == dpt_pkg::ENA_ONESHOT) begin
                            n_run[0]   = 1'b0;
                            n_cnt_main = prd0;
                        end else begin
                            if (ena0 == dpt_pkg::ENA_RELOAD) begin
                                n_prd0 = r_rel0;
                                if (!split) begin
                                    n_prd1 = r_rel1;
                                end
                            end
                            n_cnt_main = '0;
                        end
                    end else begin
                        n_cnt_main = main_inc;
                    end
                end
                if (r_run[1]) begin
                    if (match1) begin
                        n_icsr[dpt_pkg::INT_STAT_HI] = 1'b1;
                        o_res.irq_high = !plus_en || r_icsr[dpt_pkg::INT_EN_HI];
                        if (ena1 == dpt_pkg::ENA_ONESHOT) begin
                            n_run[1] = 1'b0;
                            n_cnt_hi = r_prd1[H-1:0];
                        end else begin
                            if (ena1 == dpt_pkg::ENA_RELOAD) begin
                                n_prd1 = r_rel1;
                            end
                            n_cnt_hi = '0;
                        end
                    end else begin
                        n_cnt_hi = r_cnt_hi + H'(1);
                    end
                end
            end
            dpt_pkg::OP_READ: begin
                o_res.unmapped_access = !mapped_rd;
                if (mapped_rd) begin
                    o_res.read_data = dpt_pkg::reg_take(cur_word, i_item.offset,
                                                        i_item.access_size);
                end
            end
            dpt_pkg::OP_WRITE: begin
                o_res.unmapped_access = !mapped_wr;
                if (mapped_wr) begin
                    case (wa)
                        dpt_pkg::WA_EMU:  n_emu  = wr_new;
                        dpt_pkg::WA_CNT_LO: begin
                            if (split) begin
                                n_cnt_main = W'(wr_new[H-1:0]);
                            end else begin
                                n_cnt_main = {r_cnt_main[W-1:H], wr_new[H-1:0]};
                            end
                        end
                        dpt_pkg::WA_CNT_HI: begin
                            if (split) begin
                                n_cnt_hi = wr_new[H-1:0];
                            end else begin
                                n_cnt_main = {wr_new[H-1:0], r_cnt_main[H-1:0]};
                            end
                        end
                        dpt_pkg::WA_PRD0: n_prd0 = wr_new;
                        dpt_pkg::WA_PRD1: n_prd1 = wr_new;
                        dpt_pkg::WA_TCR:  n_tcr  = wr_new;
                        dpt_pkg::WA_TGCR: n_gctl = wr_new;
                        dpt_pkg::WA_WDT:  n_wdt  = wr_new;
                        dpt_pkg::WA_REL0: n_rel0 = wr_new;
                        dpt_pkg::WA_REL1: n_rel1 = wr_new;
                        dpt_pkg::WA_INTCTL: begin
                            n_icsr = ((r_icsr & ~dpt_pkg::ENABLE_BITS) |
                                      (wr_new & dpt_pkg::ENABLE_BITS)) &
                                     ~(wr_new & dpt_pkg::STAT_BITS);
                        end
                        default: n_emu = r_emu;
                    endcase
                    // Every mapped write re-derives the run state from the
                    // values just written.
                    n_split = n_gctl[3:2] == dpt_pkg::GMODE_SPLIT;
                    if (n_split) begin
                        n_cnt_main = n_cnt_main & LOW_HALF_MASK;
                    end
                    n_run[0] = (n_tcr[dpt_pkg::ENA_SHIFT_LO +: 2] != dpt_pkg::ENA_OFF) &&
                               (n_split ? n_gctl[0] : (n_gctl[1:0] == 2'b11));
                    n_run[1] = n_split && n_gctl[1] &&
                               (n_tcr[dpt_pkg::ENA_SHIFT_HI +: 2] != dpt_pkg::ENA_OFF);
                end
            end
            default: o_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcr      <= '0;
            r_gctl     <= '0;
            r_emu      <= '0;
            r_wdt      <= '0;
            r_icsr     <= '0;
            r_prd0     <= '0;
            r_prd1     <= '0;
            r_rel0     <= '0;
            r_rel1     <= '0;
            r_cnt_main <= '0;
            r_cnt_hi   <= '0;
            r_run      <= '0;
        end else if (i_take) begin
            r_tcr      <= n_tcr;
            r_gctl     <= n_gctl;
            r_emu      <= n_emu;
            r_wdt      <= n_wdt;
            r_icsr     <= n_icsr;
            r_prd0     <= n_prd0;
            r_prd1     <= n_prd1;
            r_rel0     <= n_rel0;
            r_rel1     <= n_rel1;
            r_cnt_main <= n_cnt_main;
            r_cnt_hi   <= n_cnt_hi;
            r_run      <= n_run;
        end
    end

endmodule

`default_nettype wire

[hdl/dpt_out_stage.sv]
`default_nettype none

module dpt_out_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  dpt_pkg::t_result i_res,
    output logic             o_can_load,
    dpt_rsp_if.source        o_rsp
);

    logic             r_valid;
    dpt_pkg::t_result r_res;

    // A new result may enter when the register is empty or is being taken.
    assign o_can_load = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_rsp.valid           = r_valid;
    assign o_rsp.read_data       = r_res.read_data;
    assign o_rsp.irq_low         = r_res.irq_low;
    assign o_rsp.irq_high        = r_res.irq_high;
    assign o_rsp.unmapped_access = r_res.unmapped_access;

endmodule

`default_nettype wire

[hdl/dual_mode_period_timer.sv]
// Register-mapped period timer with reload, one 64-bit counter or two
// independent 32-bit halves, selected by the global control mode field.
// Commands arrive on i_cmd: each transaction is a timer tick, a bus read or
// a bus write. Every command transaction yields exactly one response
// transaction on o_rsp, in order, carrying read data, the two interrupt
// pulses and an unmapped-access flag.
// A command accepted on i_cmd sits in the input register, is executed
// against the timer state and lands in the output register, from which
// its response is presented on o_rsp. Throughput is one transaction per
// clock while o_rsp.ready stays high: the state update is a single pass of
// a 64-bit and a 32-bit compare and increment plus register decode.
// When the receiver holds o_rsp.ready low, the response stays in the output
// register; one more command is still taken into the input register, then
// i_cmd.ready drops until the response is taken.
// Synchronous reset (i_rst_n low) clears all timer registers and counts, stops
// both halves and empties both pipeline registers.

`default_nettype none

module dual_mode_period_timer (
    input  wire       i_clk,
    input  wire       i_rst_n,
    dpt_cmd_if.sink   i_cmd,
    dpt_rsp_if.source o_rsp
);

    logic             w_item_valid;
    dpt_pkg::t_item   w_item;
    dpt_pkg::t_result w_res;
    logic             w_can_load;
    logic             w_take;

    // A command executes when the input register holds one and the output
    // register has room for its response.
    assign w_take = w_item_valid && w_can_load;

    dpt_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    dpt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (w_item),
        .o_res   (w_res)
    );

    dpt_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_take),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

[hdl/dpt_checker.sv]
`default_nettype none

module dpt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_cmd_valid,
    input wire        i_cmd_ready,
    input wire        i_rsp_valid,
    input wire        i_rsp_ready,
    input wire [31:0] i_read_data,
    input wire        i_irq_low,
    input wire        i_irq_high,
    input wire        i_unmapped
);

    logic [2:0] r_pending, n_pending;

    // Transactions accepted but not yet answered.
    always_comb begin
        n_pending = r_pending;
        if (i_cmd_valid && i_cmd_ready) begin
            n_pending = n_pending + 3'd1;
        end
        if (i_rsp_valid && i_rsp_ready) begin
            n_pending = n_pending - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd2)
        else $error("more transactions in flight than pipeline registers");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pending != 3'd0)
        else $error("response without a pending command");

    a_irq_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_irq_low || i_irq_high) |-> !i_unmapped && i_read_data == 32'd0)
        else $error("interrupt pulse on a bus access response");

    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_unmapped |-> i_read_data == 32'd0)
        else $error("unmapped access returned data");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_read_data))
        else $error("stalled response changed");

endmodule

bind dual_mode_period_timer dpt_checker u_dpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_read_data (o_rsp.read_data),
    .i_irq_low   (o_rsp.irq_low),
    .i_irq_high  (o_rsp.irq_high),
    .i_unmapped  (o_rsp.unmapped_access)
);

`default_nettype wire
